// ----- hw/rtl/nsc_pkg.sv -----
// Shared types and constants for the nearest-center search block.
package nsc_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W + 1;
    localparam int DIST_W     = SQ_W + 1;
    localparam int ENTRY_W    = 3 * COORD_W;
    localparam int IDX_IN_W   = 5;
    localparam int IDX_OUT_W  = 5;
    localparam int ACTIVE_W   = 6;
    localparam int DEF_DEPTH  = 32;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    // Flags that travel with each center read through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_tag;

endpackage

// ----- hw/rtl/nearest_center_search.sv -----
// Nearest-center search over a RAM table of 3D centers (squared Euclidean distance).
//
// Usage:
//   Command channel: an item transfers at a rising edge with start high and busy
//   low. cmd = load writes (coord_x, coord_y, coord_z) into table slot
//   entry_index in that same edge; slots at or beyond TABLE_DEPTH are dropped.
//   cmd = query searches slots 0 .. active_entries-1 (capped at TABLE_DEPTH).
//   Result channel: o_valid strobes for exactly one cycle with o_nearest_index;
//   the receiver cannot stall, so each result must be taken in that cycle.
//   Lower slot wins on equal distance; no active slots gives index 0.
//   Configuration: i_cfg_we writes active_entries from i_cfg_data; write only
//   while busy is low and no result is pending.
// Timing:
//   A load yields no result; busy stays low.
//   A query over n slots raises busy while one RAM read per cycle walks the
//   table and a four-deep pipeline (difference, square, sum, compare)
//   drains. The next command may transfer in the cycle the result is shown.
//   With n = 0 the result shows on the next cycle and busy stays low.
// Reset: synchronous, active low; clears control state and active_entries.
//   The table contents are undefined until loaded.
module nearest_center_search #(
    parameter int TABLE_DEPTH = nsc_pkg::DEF_DEPTH,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_cmd,
    input  logic [nsc_pkg::IDX_IN_W-1:0]            i_entry_index,
    input  logic signed [nsc_pkg::COORD_W-1:0]      i_coord_x,
    input  logic signed [nsc_pkg::COORD_W-1:0]      i_coord_y,
    input  logic signed [nsc_pkg::COORD_W-1:0]      i_coord_z,
    input  logic                                    i_cfg_we,
    input  logic [nsc_pkg::ACTIVE_W-1:0]            i_cfg_data,
    output logic                                    o_valid,
    output logic [nsc_pkg::IDX_OUT_W-1:0]           o_nearest_index
);

    // Configuration register
    logic [nsc_pkg::ACTIVE_W-1:0] r_active_entries;

    // Control
    nsc_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_rd_idx, n_rd_idx;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   clamp_n;
    logic            accept, do_load, do_query, walk_last, ram_re, emit;

    // Query point
    logic signed [nsc_pkg::COORD_W-1:0] r_qx, r_qy, r_qz;

    // Table RAM
    logic [nsc_pkg::ENTRY_W-1:0] ram_rdata;
    logic                        ram_we;
    logic signed [nsc_pkg::COORD_W-1:0] c_x, c_y, c_z;

    // Distance pipeline
    nsc_pkg::t_tag r_tag1, r_tag2, r_tag3, r_tag4;
    logic [AW-1:0] r_i1, r_i2, r_i3, r_i4;
    logic signed [nsc_pkg::DIFF_W-1:0] dx, dy, dz;
    logic [nsc_pkg::DIFF_W-1:0] r_ax, r_ay, r_az;
    logic [nsc_pkg::SQ_W-1:0]   r_sx, r_sy, r_sz;
    logic [nsc_pkg::DIST_W-1:0] r_sum;
    logic [nsc_pkg::DIST_W-1:0] r_best;
    logic [AW-1:0]              r_winner, n_winner;
    logic                       upd;

    // Result register
    logic                           r_out_valid;
    logic [nsc_pkg::IDX_OUT_W-1:0]  r_out_idx;

    assign accept   = start && !busy;
    assign do_load  = accept && (i_cmd == nsc_pkg::CMD_LOAD);
    assign do_query = accept && (i_cmd == nsc_pkg::CMD_QUERY);
    assign ram_we   = do_load && (32'(i_entry_index) < TABLE_DEPTH);

    // Cap the slot count at the table depth
    always_comb begin
        if (32'(r_active_entries) > TABLE_DEPTH) begin
            clamp_n = CW'(TABLE_DEPTH);
        end else begin
            clamp_n = CW'(r_active_entries);
        end
    end

    assign walk_last = ((CW + 1)'(r_rd_idx) + (CW + 1)'(1)) == (CW + 1)'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_entries <= '0;
        end else if (i_cfg_we) begin
            r_active_entries <= i_cfg_data;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nsc_pkg::ST_IDLE: begin
                if (do_query && (clamp_n != '0)) begin
                    n_state = nsc_pkg::ST_WALK;
                end
            end
            nsc_pkg::ST_WALK: begin
                if (walk_last) begin
                    n_state = nsc_pkg::ST_DRAIN;
                end
            end
            nsc_pkg::ST_DRAIN: begin
                if (r_tag4.valid && r_tag4.last) begin
                    n_state = nsc_pkg::ST_IDLE;
                end
            end
            default: n_state = nsc_pkg::ST_IDLE;
        endcase
    end

    // State outputs: issue one RAM read per walk cycle, hold off commands while searching
    always_comb begin
        ram_re   = 1'b0;
        busy     = 1'b1;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        case (r_state)
            nsc_pkg::ST_IDLE: begin
                busy     = 1'b0;
                n_rd_idx = '0;
                if (do_query) begin
                    n_count = clamp_n;
                end
            end
            nsc_pkg::ST_WALK: begin
                ram_re   = 1'b1;
                n_rd_idx = r_rd_idx + CW'(1);
            end
            nsc_pkg::ST_DRAIN: begin
                busy = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nsc_pkg::ST_IDLE;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    // Latch the query point at transfer
    always_ff @(posedge i_clk) begin
        if (do_query) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
            r_qz <= i_coord_z;
        end
    end

    // Loads and searches never overlap: busy holds loads off during a walk
    nsc_ram #(
        .WIDTH (nsc_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata ({i_coord_x, i_coord_y, i_coord_z}),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign c_x = ram_rdata[3*nsc_pkg::COORD_W-1 -: nsc_pkg::COORD_W];
    assign c_y = ram_rdata[2*nsc_pkg::COORD_W-1 -: nsc_pkg::COORD_W];
    assign c_z = ram_rdata[nsc_pkg::COORD_W-1 -: nsc_pkg::COORD_W];

    assign dx = nsc_pkg::DIFF_W'(r_qx) - nsc_pkg::DIFF_W'(c_x);
    assign dy = nsc_pkg::DIFF_W'(r_qy) - nsc_pkg::DIFF_W'(c_y);
    assign dz = nsc_pkg::DIFF_W'(r_qz) - nsc_pkg::DIFF_W'(c_z);

    // Tag pipeline: one stage per datapath register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
        end else begin
            r_tag1.valid <= ram_re;
            r_tag1.first <= ram_re && (r_rd_idx == '0);
            r_tag1.last  <= ram_re && walk_last;
            r_tag2       <= r_tag1;
            r_tag3       <= r_tag2;
            r_tag4       <= r_tag3;
        end
    end

    // Datapath: magnitude of difference, square, sum of three
    always_ff @(posedge i_clk) begin
        r_i1  <= r_rd_idx[AW-1:0];
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_i4  <= r_i3;
        r_ax  <= dx[nsc_pkg::DIFF_W-1] ? nsc_pkg::DIFF_W'(-dx) : nsc_pkg::DIFF_W'(dx);
        r_ay  <= dy[nsc_pkg::DIFF_W-1] ? nsc_pkg::DIFF_W'(-dy) : nsc_pkg::DIFF_W'(dy);
        r_az  <= dz[nsc_pkg::DIFF_W-1] ? nsc_pkg::DIFF_W'(-dz) : nsc_pkg::DIFF_W'(dz);
        r_sx  <= nsc_pkg::SQ_W'(nsc_pkg::SQ_W'(r_ax) * nsc_pkg::SQ_W'(r_ax));
        r_sy  <= nsc_pkg::SQ_W'(nsc_pkg::SQ_W'(r_ay) * nsc_pkg::SQ_W'(r_ay));
        r_sz  <= nsc_pkg::SQ_W'(nsc_pkg::SQ_W'(r_az) * nsc_pkg::SQ_W'(r_az));
        r_sum <= nsc_pkg::DIST_W'(r_sx) + nsc_pkg::DIST_W'(r_sy) + nsc_pkg::DIST_W'(r_sz);
    end

    // Strict less-than keeps the lower slot on a tie
    assign upd      = r_tag4.first || (r_sum < r_best);
    assign n_winner = upd ? r_i4 : r_winner;
    assign emit     = r_tag4.valid && r_tag4.last;

    always_ff @(posedge i_clk) begin
        if (r_tag4.valid && upd) begin
            r_best   <= r_sum;
            r_winner <= r_i4;
        end
    end

    // Result register: one-cycle strobe, empty searches answer slot 0 at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
        end else begin
            r_out_valid <= emit || (do_query && (clamp_n == '0));
            if (emit) begin
                r_out_idx <= nsc_pkg::IDX_OUT_W'(n_winner);
            end else if (do_query) begin
                r_out_idx <= '0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_nearest_index = r_out_idx;

    // Walk address stays inside the active range
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nsc_pkg::ST_WALK) |-> (r_rd_idx < r_count))
        else $error("walk address beyond active range");

    // Last compare always produces a result next cycle
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag4.valid && r_tag4.last) |=> o_valid)
        else $error("search finished without result");

    // A search only starts on a query transfer
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && (i_cmd == nsc_pkg::CMD_QUERY)))
        else $error("busy raised without query transfer");

    // No table read while idle
    a_idle_noread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !ram_re)
        else $error("table read while idle");

endmodule

// ----- hw/rtl/nsc_ram.sv -----
// Generic single-port-write, registered-read RAM.
module nsc_ram #(
    parameter int WIDTH = nsc_pkg::ENTRY_W,
    parameter int DEPTH = nsc_pkg::DEF_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/nearest_center_search_tb.sv -----
// Self-checking testbench for the nearest-center search block.
module nearest_center_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   COORD_W   = nsc_pkg::COORD_W;
    localparam int   IDX_IN_W  = nsc_pkg::IDX_IN_W;
    localparam int   IDX_OUT_W = nsc_pkg::IDX_OUT_W;
    localparam int   ACTIVE_W  = nsc_pkg::ACTIVE_W;
    localparam int   DEF_DEPTH = nsc_pkg::DEF_DEPTH;
    localparam logic CMD_LOAD  = nsc_pkg::CMD_LOAD;
    localparam logic CMD_QUERY = nsc_pkg::CMD_QUERY;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 8;      // quiet cycles before a register write
    localparam int DRAIN_CYCLES   = 64;     // drain wait after the last result
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer at all
    localparam int RANDOM_ITEMS   = 1200;
    localparam int IDLE_PERCENT   = 16;
    localparam int CALM_FIRST     = 300;    // transfers between these two counts
    localparam int CALM_LAST      = 550;    // are sent without any idling

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // A queued step is either a command transfer or a register write.
    typedef enum logic {
        STEP_CMD,
        STEP_CFG
    } t_step_kind;

    typedef struct {
        t_step_kind                 kind;
        logic                       cmd;
        logic [IDX_IN_W-1:0]        slot;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [ACTIVE_W-1:0]        active;
    } t_step;

    // DUT connections; every input starts at a known value.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       i_cmd = CMD_LOAD;
    logic [IDX_IN_W-1:0]        i_entry_index = '0;
    logic signed [COORD_W-1:0]  i_coord_x = '0;
    logic signed [COORD_W-1:0]  i_coord_y = '0;
    logic signed [COORD_W-1:0]  i_coord_z = '0;
    logic                       i_cfg_we = 1'b0;
    logic [ACTIVE_W-1:0]        i_cfg_data = '0;
    logic                       o_valid;
    logic [IDX_OUT_W-1:0]       o_nearest_index;

    // Stimulus waiting to be driven, and nearest slots waiting to come out.
    t_step                      pending_steps[$];
    logic [IDX_OUT_W-1:0]       expected_slots[$];

    // Predictor state: mirror of the center table and the active count.
    logic signed [COORD_W-1:0]  table_x[DEF_DEPTH];
    logic signed [COORD_W-1:0]  table_y[DEF_DEPTH];
    logic signed [COORD_W-1:0]  table_z[DEF_DEPTH];
    logic [ACTIVE_W-1:0]        active_count;

    // Generator-side copy of the table, used to aim queries near real centers
    // and to plant duplicate centers for ties.
    logic signed [COORD_W-1:0]  gen_x[DEF_DEPTH];
    logic signed [COORD_W-1:0]  gen_y[DEF_DEPTH];
    logic signed [COORD_W-1:0]  gen_z[DEF_DEPTH];

    int                         error_count = 0;
    int                         queued_cmds = 0;
    int                         sent_cmds = 0;
    int                         quiet_cycles = 0;
    int                         stall_cycles = 0;

    nearest_center_search dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_entry_index   (i_entry_index),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_nearest_index (o_nearest_index)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hold reset at the start, then release it once for the whole run.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Exact square of one coordinate gap; the gap needs 25 bits, the square 48.
    function automatic logic [63:0] gap_squared(input logic signed [COORD_W-1:0] a,
                                                input logic signed [COORD_W-1:0] b);
        longint gap;
        gap = longint'(a) - longint'(b);
        return 64'(gap * gap);
    endfunction

    // Walk the active slots, keep the strictly smaller distance so the lower
    // slot wins a tie; no active slots leaves slot 0.
    function automatic logic [IDX_OUT_W-1:0] nearest_slot(input logic signed [COORD_W-1:0] px,
                                                          input logic signed [COORD_W-1:0] py,
                                                          input logic signed [COORD_W-1:0] pz);
        int          walk_len;
        logic [63:0] best_dist;
        logic [63:0] cand_dist;
        logic [IDX_OUT_W-1:0] winner;
        // Counts above the table depth saturate at the depth.
        walk_len  = (int'(active_count) > DEF_DEPTH) ? DEF_DEPTH : int'(active_count);
        best_dist = '0;
        winner    = '0;
        for (int i = 0; i < walk_len; i++) begin
            cand_dist = gap_squared(px, table_x[i]) + gap_squared(py, table_y[i])
                      + gap_squared(pz, table_z[i]);
            if (i == 0 || cand_dist < best_dist) begin
                best_dist = cand_dist;
                winner    = IDX_OUT_W'(i);
            end
        end
        return winner;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic queue_load(input logic [IDX_IN_W-1:0] slot,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z);
        t_step s;
        s = '{kind: STEP_CMD, cmd: CMD_LOAD, slot: slot, x: x, y: y, z: z, active: '0};
        pending_steps.push_back(s);
        gen_x[slot] = x;
        gen_y[slot] = y;
        gen_z[slot] = z;
        queued_cmds++;
    endtask

    // The slot field is don't-care for a query; fill it anyway to toggle it.
    task automatic queue_query(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z);
        t_step s;
        s = '{kind: STEP_CMD, cmd: CMD_QUERY, slot: IDX_IN_W'($urandom), x: x, y: y, z: z,
              active: '0};
        pending_steps.push_back(s);
        queued_cmds++;
    endtask

    task automatic queue_active(input logic [ACTIVE_W-1:0] count);
        t_step s;
        s = '{kind: STEP_CFG, cmd: CMD_LOAD, slot: '0, x: '0, y: '0, z: '0, active: count};
        pending_steps.push_back(s);
    endtask

    // Mix of extremes, a tight cluster near zero, and full-range values.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3, 4: return COORD_W'(int'($urandom_range(0, 32)) - 16);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Offset a known center a little so the query lands close to it; wraps at
    // the range ends are just other legal points.
    function automatic logic signed [COORD_W-1:0] nudge(input logic signed [COORD_W-1:0] c);
        return c + COORD_W'(int'($urandom_range(0, 6)) - 3);
    endfunction

    function automatic logic [ACTIVE_W-1:0] pick_active();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ACTIVE_W'(1);
            2: return ACTIVE_W'(DEF_DEPTH);
            3: return ACTIVE_W'(DEF_DEPTH + 1);
            4: return '1;
            default: return ACTIVE_W'($urandom_range(0, (1 << ACTIVE_W) - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned src;
        int unsigned dst;
        int unsigned roll;
        int          phase_len;

        // Empty search: no active slots must give slot 0, at both coordinate ends.
        queue_active('0);
        queue_query(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_query(COORD_MIN, COORD_MIN, COORD_MIN);

        // Corner centers, plus two identical centers for a tie and the top slot.
        queue_load('0, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_load(IDX_IN_W'(1), COORD_MIN, COORD_MIN, COORD_MIN);
        queue_load(IDX_IN_W'(2), '0, '0, '0);
        queue_load(IDX_IN_W'(3), '0, '0, '0);
        queue_load('1, COORD_W'(1), COORD_W'(-1), COORD_W'(1));

        // Four active slots: each corner, the tie at the origin, a mixed point.
        queue_active(ACTIVE_W'(4));
        queue_query(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_query(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_query('0, '0, '0);
        queue_query(COORD_MIN, COORD_MAX, COORD_MIN);
        queue_query(COORD_W'(-1), COORD_W'(-1), COORD_W'(-1));

        // A single active slot always wins.
        queue_active(ACTIVE_W'(1));
        queue_query(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_query(pick_coord(), pick_coord(), pick_coord());

        // Fill every slot before any wider search can reach it.
        for (int i = 0; i < DEF_DEPTH; i++) begin
            queue_load(IDX_IN_W'(i), pick_coord(), pick_coord(), pick_coord());
        end

        // Random phases: new active count, then mostly queries with some reloads.
        while (queued_cmds < RANDOM_ITEMS + 50) begin
            queue_active(pick_active());
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 25) begin
                    queue_load(IDX_IN_W'($urandom), pick_coord(), pick_coord(), pick_coord());
                end else if (roll < 30) begin
                    // Duplicate a center into another slot to force ties.
                    src = $urandom_range(0, DEF_DEPTH - 1);
                    dst = $urandom_range(0, DEF_DEPTH - 1);
                    queue_load(IDX_IN_W'(dst), gen_x[src], gen_y[src], gen_z[src]);
                end else if (roll < 60) begin
                    src = $urandom_range(0, DEF_DEPTH - 1);
                    queue_query(nudge(gen_x[src]), nudge(gen_y[src]), nudge(gen_z[src]));
                end else begin
                    queue_query(pick_coord(), pick_coord(), pick_coord());
                end
            end
        end

        // Wait for the last transfer, then for every result, then drain.
        while (pending_steps.size() != 0 || start) @(posedge i_clk);
        while (expected_slots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_slots.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_slots.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: present one step at a time, hold start until the transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_step head;
        logic  fire;
        logic  take_break;
        logic  next_start;
        logic  next_we;

        fire       = start && !busy;
        next_start = start;
        next_we    = 1'b0;

        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (fire) begin
                sent_cmds++;
            end
            // Count cycles with nothing in flight; register writes wait on it.
            if (start || busy || o_valid || i_cfg_we || expected_slots.size() != 0) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end

            if (!start || fire) begin
                // Idle now and then, except in the calm stretch.
                take_break = ($urandom_range(0, 99) < IDLE_PERCENT)
                          && !(sent_cmds >= CALM_FIRST && sent_cmds < CALM_LAST);
                next_start = 1'b0;
                if (pending_steps.size() != 0 && !take_break) begin
                    if (pending_steps[0].kind == STEP_CFG) begin
                        // Hold the write until the block has fully settled.
                        if (quiet_cycles >= SETTLE_CYCLES && !fire) begin
                            head = pending_steps.pop_front();
                            i_cfg_data <= head.active;
                            next_we = 1'b1;
                        end
                    end else begin
                        head = pending_steps.pop_front();
                        i_cmd         <= head.cmd;
                        i_entry_index <= head.slot;
                        i_coord_x     <= head.x;
                        i_coord_y     <= head.y;
                        i_coord_z     <= head.z;
                        next_start = 1'b1;
                    end
                end
            end
        end

        start    <= next_start;
        i_cfg_we <= next_we;
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then track writes and transfers at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [IDX_OUT_W-1:0] want;

        if (i_rst_n) begin
            // A result and a new transfer may share an edge; check the older first.
            if (o_valid) begin
                if (expected_slots.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual slot %0d",
                             $time, o_nearest_index);
                    error_count++;
                end else begin
                    want = expected_slots.pop_front();
                    if (o_nearest_index !== want) begin
                        $display("%0t: nearest_index mismatch, expected %0d, actual %0d",
                                 $time, want, o_nearest_index);
                        error_count++;
                    end
                end
            end

            if (i_cfg_we) begin
                active_count = i_cfg_data;
            end

            if (start && !busy) begin
                if (i_cmd == CMD_LOAD) begin
                    table_x[i_entry_index] = i_coord_x;
                    table_y[i_entry_index] = i_coord_y;
                    table_z[i_entry_index] = i_coord_z;
                end else begin
                    expected_slots.push_back(nearest_slot(i_coord_x, i_coord_y, i_coord_z));
                end
            end
        end else begin
            active_count = '0;
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || i_cfg_we) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule
